@@ rtl/cpna_pkg.sv @@
// shared types, codes and defaults of the channel pedestal and noise accumulator
package cpna_pkg;

	localparam int CHANNELS_DEF   = 2048;
	localparam int GAINS_DEF      = 3;
	localparam int ADC_BITS_DEF   = 12;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CHAN_FIELD_W  = 11;
	localparam int GAIN_FIELD_W  = 2;
	localparam int ADC_FIELD_W   = 12;
	localparam int COUNT_FIELD_W = 16;
	localparam int PED_W         = 20;
	localparam int NOISE_W       = 19;
	localparam int CFG_W         = 12;
	localparam int FRAC_BITS     = 8;

	localparam logic [CFG_W-1:0] CHANNELS_IN_USE_RST = 12'd2048;
	localparam logic [1:0]       FIRST_GAIN_RST      = 2'd1;

	typedef enum logic [0:0] {
		CFG_CHANNELS_IN_USE = 1'b0,
		CFG_FIRST_GAIN_CODE = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		OP_ACCUMULATE = 1'b0,
		OP_READ       = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCUMULATED = 3'd0,
		ST_BAD_GAIN    = 3'd1,
		ST_BAD_CHANNEL = 3'd2,
		ST_COUNT_FULL  = 3'd3,
		ST_READ_DONE   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_MUL2,
		S_SUB,
		S_SQRT,
		S_NDIV,
		S_NOISE,
		S_HOLD
	} fsm_t;

endpackage

@@ rtl/channel_pedestal_noise_accumulator.sv @@
// top level of the channel pedestal and noise accumulator
// Keeps a sample count, an ADC sum and a sum of squares for every channel and gain range
// in one on-chip memory (GAINS*CHANNELS entries, 6144 by default). After reset a clearing
// pass writes every entry to zero, one per cycle; no item is taken meanwhile,
// configuration writes are. Items are handled one at a time: an accumulate item goes
// through memory read, read-modify-write and output load, and a dropped item goes to the
// output load right after the transfer. A read item with a nonzero count runs the pedestal
// divide in parallel with the bit-serial square root and then divides the root by the
// count. The next item is taken while a result still waits in the output register.
// Pedestal is unsigned 12.8 and noise unsigned 11.8, floored.
module channel_pedestal_noise_accumulator import cpna_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int GAINS      = GAINS_DEF,
	parameter int ADC_BITS   = ADC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // channel, gain_code, adc_value, zero fill
	input  logic [0:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // sample_count, pedestal, noise, zero fill
	output logic [2:0]  m_axis_tuser,  // status
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int ENTRIES = GAINS * CHANNELS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW      = COUNT_BITS;
	localparam int SW      = ADC_BITS + CW;
	localparam int QW      = 2 * ADC_BITS + CW;
	localparam int EW      = CW + SW + QW;
	localparam int PW      = CW + QW;
	localparam int XW      = SW + FRAC_BITS;
	localparam int QL      = QW / 2;
	localparam int QH      = QW - QL;

	// configuration registers
	logic [CFG_W-1:0] chan_in_use_q;
	logic [1:0]       first_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_in_use_q <= CHANNELS_IN_USE_RST;
			first_gain_q  <= FIRST_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNELS_IN_USE: chan_in_use_q <= cfg_data;
				CFG_FIRST_GAIN_CODE: first_gain_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [CHAN_FIELD_W-1:0] in_ch;
	logic [GAIN_FIELD_W-1:0] in_gc;
	logic [ADC_BITS-1:0]     in_adc;
	logic [2:0]              gdiff;
	logic                    bad_ch;
	logic                    bad_gain;
	logic [AW-1:0]           in_addr;

	always_comb begin
		in_ch    = s_axis_tdata[10:0];
		in_gc    = s_axis_tdata[12:11];
		in_adc   = ADC_BITS'(s_axis_tdata[24:13]);
		gdiff    = {1'b0, in_gc} - {1'b0, first_gain_q};
		bad_ch   = ({1'b0, in_ch} >= chan_in_use_q) || (32'(in_ch) >= CHANNELS);
		bad_gain = (in_gc < first_gain_q) || (32'(gdiff) >= GAINS);
		in_addr  = AW'(32'(gdiff[1:0]) * CHANNELS + 32'(in_ch));
	end

	fsm_t state_q, state_d;

	logic accept;
	logic store_busy;
	logic [EW-1:0] rd_data;
	logic          wr_en;
	logic [EW-1:0] wr_data;

	// item context
	logic          op_q;
	logic [AW-1:0] addr_q;
	logic [ADC_BITS-1:0]   adc_q;
	logic [2*ADC_BITS-1:0] adc_sq_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] s_q;
	logic [QW-1:0] q_q;
	logic [CW+QL-1:0] plo_s1;
	logic [PW-1:0]    ss_s1;
	logic [PW-1:0]    nq_s2;
	logic [XW-1:0]    root_q;
	logic             ped_done_q;

	// result
	status_t            res_status_q;
	logic [CW-1:0]      res_cnt_q;
	logic [PED_W-1:0]   res_ped_q;
	logic [NOISE_W-1:0] res_noise_q;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [COUNT_FIELD_W-1:0] out_cnt_q;
	logic [PED_W-1:0]         out_ped_q;
	logic [NOISE_W-1:0]       out_noise_q;

	logic [CW-1:0] rd_n;
	logic [SW-1:0] rd_s;
	logic [QW-1:0] rd_q;
	logic          out_free;

	logic          div_start;
	logic [XW-1:0] div_dividend;
	logic [XW-1:0] div_quot;
	logic          div_done;
	logic          sqrt_start;
	logic [XW-1:0] sqrt_root;
	logic          sqrt_done;
	logic          nq_ge;
	logic [PW-1:0] diff;

	assign accept   = s_axis_tvalid & s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		rd_n  = rd_data[CW-1:0];
		rd_s  = rd_data[CW+SW-1:CW];
		rd_q  = rd_data[EW-1:CW+SW];
		nq_ge = nq_s2 >= ss_s1;
		diff  = nq_s2 - ss_s1;
	end

	cpna_store #(.ENTRIES(ENTRIES), .EW(EW), .AW(AW)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_data),
		.busy    (store_busy)
	);

	cpna_divider #(.XW(XW), .DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (n_q),
		.quotient (div_quot),
		.done     (div_done)
	);

	cpna_sqrt #(.RTW(XW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({diff, 16'd0}),
		.root     (sqrt_root),
		.done     (sqrt_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		div_start     = 1'b0;
		sqrt_start    = 1'b0;
		div_dividend  = {s_q, 8'd0};
		case (state_q)
			S_IDLE: begin
				s_axis_tready = !store_busy;
				if (accept) begin
					state_d = (bad_ch || bad_gain) ? S_HOLD : S_READ;
				end
			end
			S_READ: begin
				if (op_q == OP_ACCUMULATE) begin
					wr_en   = rd_n != {CW{1'b1}};
					state_d = S_HOLD;
				end else begin
					state_d = (rd_n == '0) ? S_HOLD : S_MUL;
				end
			end
			S_MUL: begin
				// pedestal divide overlaps the noise path
				div_start = 1'b1;
				state_d   = S_MUL2;
			end
			S_MUL2: state_d = S_SUB;
			S_SUB: begin
				sqrt_start = nq_ge;
				state_d    = nq_ge ? S_SQRT : S_NDIV;
			end
			S_SQRT: begin
				if (sqrt_done) begin
					state_d = S_NDIV;
				end
			end
			S_NDIV: begin
				div_dividend = root_q;
				if (ped_done_q) begin
					div_start = 1'b1;
					state_d   = S_NOISE;
				end
			end
			S_NOISE: begin
				if (div_done) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign wr_data = {rd_q + QW'(adc_sq_q), rd_s + SW'(adc_q), rd_n + 1'b1};

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q        <= s_axis_tuser[0];
				addr_q      <= in_addr;
				adc_q       <= in_adc;
				adc_sq_q    <= in_adc * in_adc;
				res_cnt_q   <= '0;
				res_ped_q   <= '0;
				res_noise_q <= '0;
				res_status_q <= bad_ch ? ST_BAD_CHANNEL : ST_BAD_GAIN;
			end
			S_READ: begin
				n_q <= rd_n;
				s_q <= rd_s;
				q_q <= rd_q;
				if (op_q == OP_ACCUMULATE) begin
					if (rd_n == {CW{1'b1}}) begin
						res_status_q <= ST_COUNT_FULL;
						res_cnt_q    <= rd_n;
					end else begin
						res_status_q <= ST_ACCUMULATED;
						res_cnt_q    <= rd_n + 1'b1;
					end
				end else begin
					res_status_q <= ST_READ_DONE;
					res_cnt_q    <= rd_n;
				end
			end
			S_MUL: begin
				plo_s1 <= n_q * q_q[QL-1:0];
				ss_s1  <= s_q * s_q;
			end
			S_MUL2: begin
				nq_s2 <= PW'(plo_s1) + (PW'(n_q * q_q[QW-1:QL]) << QL);
			end
			S_SUB: begin
				root_q <= '0;
			end
			S_SQRT: begin
				if (sqrt_done) begin
					root_q <= sqrt_root;
				end
			end
			S_NOISE: begin
				if (div_done) begin
					res_noise_q <= NOISE_W'(div_quot);
				end
			end
			default: ;
		endcase
		if (div_done && state_q != S_NOISE) begin
			res_ped_q <= PED_W'(div_quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ped_done_q <= 1'b0;
		end else if (state_q == S_MUL) begin
			ped_done_q <= 1'b0;
		end else if (div_done) begin
			ped_done_q <= 1'b1;
		end
	end

	// output register, loaded once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			out_status_q <= res_status_q;
			out_cnt_q    <= COUNT_FIELD_W'(res_cnt_q);
			out_ped_q    <= res_ped_q;
			out_noise_q  <= res_noise_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {1'b0, out_noise_q, out_ped_q, out_cnt_q};

	// no transfer in while the clearing pass runs
	a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !s_axis_tready)
		else $error("item taken during clearing pass");

	// a dropped item never carries values
	a_dropped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_BAD_GAIN || m_axis_tuser == ST_BAD_CHANNEL))
		|-> (m_axis_tdata == '0))
		else $error("dropped item with nonzero fields");

	// an accumulated sample leaves a nonzero count
	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_ACCUMULATED) |-> (m_axis_tdata[15:0] != '0))
		else $error("accumulate result with zero count");

	// memory written only in the read-modify-write step
	a_write_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_READ && op_q == OP_ACCUMULATE))
		else $error("stray memory write");

endmodule

@@ rtl/cpna_store.sv @@
// entry memory with registered read and a clearing pass after reset
module cpna_store import cpna_pkg::*; #(
	parameter int ENTRIES = GAINS_DEF * CHANNELS_DEF,
	parameter int EW      = 84,
	parameter int AW      = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data,
	output logic          busy
);

	logic [EW-1:0] mem [ENTRIES];
	logic [AW-1:0] clr_addr_q;
	logic          clr_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [EW-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(ENTRIES - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		we = clr_q | wr_en;
		wa = clr_q ? clr_addr_q : wr_addr;
		wd = clr_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = clr_q;

endmodule

@@ rtl/cpna_divider.sv @@
// restoring divider, one quotient bit per cycle
module cpna_divider import cpna_pkg::*; #(
	parameter int XW = 36,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [XW-1:0] quotient,
	output logic          done
);

	localparam int CNTW = $clog2(XW + 1);

	logic [XW-1:0]   x_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   d_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [DW:0]     raw;
	logic            take;

	always_comb begin
		raw  = {rem_q, x_q[XW-1]};
		take = raw >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(XW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? DW'(raw - {1'b0, d_q}) : DW'(raw);
			x_q   <= {x_q[XW-2:0], take};
		end
	end

	assign quotient = x_q;
	assign done     = done_q;

endmodule

@@ rtl/cpna_sqrt.sv @@
// digit-by-digit integer square root, one root bit per cycle
module cpna_sqrt import cpna_pkg::*; #(
	parameter int RTW = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*RTW-1:0] radicand,
	output logic [RTW-1:0]   root,
	output logic             done
);

	localparam int RW   = 2 * RTW;
	localparam int CNTW = $clog2(RTW + 1);

	logic [RW-1:0]   rad_q;
	logic [RTW:0]    rem_q;
	logic [RTW-1:0]  root_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RTW+2:0]  raw;
	logic [RTW+2:0]  trial;
	logic            take;

	always_comb begin
		raw   = {rem_q, rad_q[RW-1:RW-2]};
		trial = {1'b0, root_q, 2'b01};
		take  = raw >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(RTW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rem_q  <= take ? (RTW+1)'(raw - trial) : (RTW+1)'(raw);
			rad_q  <= {rad_q[RW-3:0], 2'b00};
			root_q <= {root_q[RTW-2:0], take};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

@@ test/tb_top.sv @@
// self-checking testbench of the channel pedestal and noise accumulator
`timescale 1ns / 1ps

module tb_top;
	import cpna_pkg::*;

	localparam int NCH   = CHANNELS_DEF;
	localparam int NGAIN = GAINS_DEF;
	localparam logic [15:0] FULL_COUNT = 16'hFFFF;

	typedef struct packed {
		status_t     status;
		logic [15:0] sample_count;
		logic [19:0] pedestal;
		logic [18:0] noise;
	} readout_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [11:0] cfg_data;

	// predictor state: exact sums per gain range and channel
	logic [15:0] pred_count [NGAIN*NCH];
	logic [27:0] pred_sum   [NGAIN*NCH];
	logic [39:0] pred_sq    [NGAIN*NCH];
	logic [11:0] pred_channels;
	logic [1:0]  pred_first_gain;

	readout_t expected_q[$];
	int       errors;
	bit       sink_stall_on;

	channel_pedestal_noise_accumulator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// floor of the square root by bit-serial restoring method
	function automatic logic [63:0] isqrt(logic [127:0] num);
		logic [127:0] res;
		logic [127:0] bitv;
		res = '0;
		bitv = 128'd1 << 126;
		while (bitv != 0 && bitv > num) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num = num - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[63:0];
	endfunction

	// expected response of one item; updates the predicted store
	function automatic readout_t predict_readout(op_t op, logic [10:0] ch, logic [1:0] gc,
			logic [11:0] adc);
		readout_t r;
		int idx;
		logic [127:0] nq, ss;
		logic [63:0] n, s;
		r = '0;
		if (ch >= pred_channels) begin
			r.status = ST_BAD_CHANNEL;
		end else if (gc < pred_first_gain || gc - pred_first_gain >= NGAIN) begin
			r.status = ST_BAD_GAIN;
		end else begin
			idx = int'(gc - pred_first_gain) * NCH + ch;
			n = pred_count[idx];
			s = pred_sum[idx];
			if (op == OP_ACCUMULATE) begin
				if (pred_count[idx] == FULL_COUNT) begin
					r.status = ST_COUNT_FULL;
					r.sample_count = FULL_COUNT;
				end else begin
					pred_count[idx] = pred_count[idx] + 1;
					pred_sum[idx] = pred_sum[idx] + adc;
					pred_sq[idx] = pred_sq[idx] + 40'(adc) * adc;
					r.status = ST_ACCUMULATED;
					r.sample_count = pred_count[idx];
				end
			end else begin
				r.status = ST_READ_DONE;
				r.sample_count = pred_count[idx];
				if (n != 0) begin
					nq = 128'(n) * pred_sq[idx];
					ss = 128'(s) * s;
					r.pedestal = 20'((s << 8) / n);
					if (nq >= ss) r.noise = 19'(isqrt((nq - ss) << 16) / n);
				end
			end
		end
		return r;
	endfunction

	// sends one item and queues its expected readout; valid drops before an idle gap
	task automatic send_item(op_t op, logic [10:0] ch, logic [1:0] gc, logic [11:0] adc);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, adc, gc, ch};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_q.push_back(predict_readout(op, ch, gc, adc));
		@(negedge clk);
	endtask

	// waits until every readout arrived, then lets the read pipeline drain
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [11:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHANNELS_IN_USE) pred_channels = val;
		else pred_first_gain = val[1:0];
	endtask

	// readout checker; the sink stalls at random before each transfer when sink_stall_on is set
	initial begin
		readout_t got, exp_r;
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_stall_on ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got.status       = status_t'(m_axis_tuser);
			got.sample_count = m_axis_tdata[15:0];
			got.pedestal     = m_axis_tdata[35:16];
			got.noise        = m_axis_tdata[54:36];
			if (expected_q.size() == 0) begin
				$error("readout with no item outstanding: %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.status != exp_r.status) begin
					$error("status expected %0d actual %0d", exp_r.status, got.status);
					errors++;
				end
				if (got.sample_count != exp_r.sample_count) begin
					$error("sample_count expected %0d actual %0d", exp_r.sample_count,
						got.sample_count);
					errors++;
				end
				if (got.pedestal != exp_r.pedestal) begin
					$error("pedestal expected %0d actual %0d", exp_r.pedestal, got.pedestal);
					errors++;
				end
				if (got.noise != exp_r.noise) begin
					$error("noise expected %0d actual %0d", exp_r.noise, got.noise);
					errors++;
				end
			end
		end
	end

	// field extremes, every status but count full, both operations
	task automatic test_directed();
		send_item(OP_READ, 11'd0, 2'd1, 12'd0);             // empty entry reads zero
		send_item(OP_ACCUMULATE, 11'd0, 2'd1, 12'd0);
		send_item(OP_ACCUMULATE, 11'd0, 2'd1, 12'hFFF);
		send_item(OP_READ, 11'd0, 2'd1, 12'hFFF);
		send_item(OP_ACCUMULATE, 11'd2047, 2'd3, 12'hFFF);
		send_item(OP_ACCUMULATE, 11'd2047, 2'd3, 12'hFFF);
		send_item(OP_READ, 11'd2047, 2'd3, 12'd0);          // constant samples, zero noise
		send_item(OP_ACCUMULATE, 11'd5, 2'd0, 12'd100);     // gain below window
		send_item(OP_READ, 11'd5, 2'd0, 12'd0);
		send_item(OP_ACCUMULATE, 11'd1234, 2'd2, 12'h555);
		send_item(OP_ACCUMULATE, 11'd1234, 2'd2, 12'hAAA);
		send_item(OP_ACCUMULATE, 11'd1234, 2'd2, 12'h001);
		send_item(OP_READ, 11'd1234, 2'd2, 12'd0);
		wait_drained();
		write_reg(CFG_CHANNELS_IN_USE, 12'd16);
		write_reg(CFG_FIRST_GAIN_CODE, 2'd0);
		send_item(OP_ACCUMULATE, 11'd16, 2'd0, 12'd7);      // channel not in use
		send_item(OP_READ, 11'd2047, 2'd0, 12'd7);
		send_item(OP_ACCUMULATE, 11'd15, 2'd3, 12'd7);      // gain above window
		send_item(OP_ACCUMULATE, 11'd15, 2'd2, 12'd7);
		send_item(OP_READ, 11'd15, 2'd2, 12'd7);
		wait_drained();
		write_reg(CFG_CHANNELS_IN_USE, 12'd0);              // every channel bad
		send_item(OP_ACCUMULATE, 11'd0, 2'd0, 12'd1);
		send_item(OP_READ, 11'd0, 2'd1, 12'd1);
		wait_drained();
	endtask

	// random mixed traffic over a few channels under the given register settings
	task automatic test_random(int items, logic [11:0] chans, logic [1:0] first_gain);
		op_t op;
		logic [10:0] ch;
		logic [1:0] gc;
		write_reg(CFG_CHANNELS_IN_USE, chans);
		write_reg(CFG_FIRST_GAIN_CODE, first_gain);
		for (int i = 0; i < items; i++) begin
			op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ACCUMULATE;
			if ($urandom_range(0, 9) == 0) ch = 11'($urandom);
			else ch = 11'($urandom_range(0, 7)) | ($urandom_range(0, 1) ? 11'h7F8 : 11'h0);
			gc = 2'($urandom);
			send_item(op, ch, gc, 12'($urandom));
			if (i == items / 2) wait_drained();   // sender holds until all readouts are in
		end
		wait_drained();
	endtask

	initial begin
		errors = 0;
		sink_stall_on = 1'b1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CHANNELS_IN_USE;
		cfg_data = '0;
		pred_channels = CHANNELS_IN_USE_RST;
		pred_first_gain = FIRST_GAIN_RST;
		for (int i = 0; i < NGAIN*NCH; i++) begin
			pred_count[i] = '0;
			pred_sum[i] = '0;
			pred_sq[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(250, 12'd2048, 2'd0);
		test_random(250, 12'd2047, 2'd1);
		test_random(250, 12'd1, 2'd3);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
